// ===== hw/rtl/sample_voice_mixer_macros.svh =====
// Assertion macros for the sample voice mixer.
`ifndef SAMPLE_VOICE_MIXER_MACROS_SVH
`define SAMPLE_VOICE_MIXER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define SVM_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SVM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SVM_ASSERT_SAME(lbl, ck, rn, ante, cons, msg)
`define SVM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/svm_pkg.sv =====
// Types, op codes and reset constants for the sample voice mixer.
package svm_pkg;

  localparam int VOICES_DEF      = 8;
  localparam int VOICE_DEPTH_DEF = 65536;
  localparam int MUSIC_DEPTH_DEF = 4096;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_TRIGGER   = 3'd1;
  localparam logic [2:0] OP_WR_VOICE  = 3'd2;
  localparam logic [2:0] OP_WR_MUSIC  = 3'd3;
  localparam logic [2:0] OP_SET_LEN   = 3'd4;

  localparam logic [16:0] VOL_RESET   = 17'd16384;
  localparam logic [15:0] MIX_BIAS    = 16'h8000;
  localparam logic [15:0] SAMPLE_MAX  = 16'hffff;

  localparam logic [16:0] END_RESET [16] = '{
    17'd2360, 17'd33748, 17'd4608, 17'd26217,
    17'd2048, 17'd1882,  17'd28922, 17'd9939,
    17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };

  typedef struct packed {
    logic       swap;
    logic       fill;
    logic [7:0] mask;
  } svm_side_t;

endpackage

// ===== hw/rtl/sample_voice_mixer.sv =====
// Sample voice mixer: banked voice memories, ping-pong music memory, mix and gain.
// A tick word passes the stage registers v1_r, v2_r and v3_r, then the output register.
// Throughput: one word per cycle while in_stall is low; every voice bank and each
// music bank has its own read port, so a tick needs one read per memory. Non-tick
// words make no result. Reset (rst_n low, synchronous): voice state, volume and music
// position reload; both music banks are then zeroed with in_stall high.
`include "sample_voice_mixer_macros.svh"

module sample_voice_mixer
  import svm_pkg::*;
#(
  parameter int VOICES      = VOICES_DEF,
  parameter int VOICE_DEPTH = VOICE_DEPTH_DEF,
  parameter int MUSIC_DEPTH = MUSIC_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [2:0]  in_voice,
  input  logic [15:0] in_index,
  input  logic [15:0] in_sample_value,
  input  logic        in_buffer_select,
  input  logic [16:0] in_voice_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_dac_sample,
  output logic        out_swap_pulse,
  output logic        out_buffer_to_fill,
  output logic [7:0]  out_active_voices
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = $clog2(VOICE_DEPTH);
  localparam int MW = $clog2(MUSIC_DEPTH);
  localparam logic [MW-1:0] MPOS_LAST = MW'(MUSIC_DEPTH - 1);

  // control and config
  logic [16:0]   vol_r;
  logic          clr_r;
  logic [MW-1:0] clr_cnt_r;
  logic [MW-1:0] mpos_r;
  logic          abuf_r;

  logic [VOICES-1:0] play_r, play_nxt;
  logic [16:0]       pos_r [VOICES];
  logic [16:0]       pos_nxt [VOICES];
  logic [16:0]       end_r [VOICES];
  logic [16:0]       end_nxt [VOICES];

  // pipeline
  logic        v1_r, v2_r, v3_r, out_valid_r;
  logic        en1, en2, en3, adv_out;
  svm_side_t   side_nxt, side1_r, side2_r, side3_r;
  logic [VOICES-1:0] vmask1_r;
  logic        msel1_r;
  logic [15:0] vrd_r [VOICES];
  logic [15:0] mrd0_r, mrd1_r;
  logic [15:0] mix_nxt, mix2_r;
  logic [32:0] prod3_r;
  logic [15:0] dac_r;

  logic          acc, tick_acc, trig_acc, vok, vidx_ok, midx_ok, swap_now;
  logic [VW-1:0] voice_idx;

  assign adv_out  = !out_valid_r || !out_stall;
  assign en3      = !v3_r || adv_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = clr_r || !en1;

  assign acc       = in_valid && !in_stall;
  assign voice_idx = VW'(in_voice);
  assign vok       = 32'(in_voice) < VOICES;
  assign vidx_ok   = {1'b0, in_index} < 17'(VOICE_DEPTH);
  assign midx_ok   = {1'b0, in_index} < 17'(MUSIC_DEPTH);
  assign tick_acc  = acc && (in_op == OP_TICK);
  assign trig_acc  = acc && (in_op == OP_TRIGGER) && vok;
  assign swap_now  = (mpos_r == MPOS_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r <= VOL_RESET;
    end else if (cfg_wr_en) begin
      vol_r <= cfg_wr_data;
    end
  end

  // voice state
  always_comb begin
    for (int v = 0; v < VOICES; v++) begin
      play_nxt[v] = play_r[v];
      pos_nxt[v]  = pos_r[v];
      end_nxt[v]  = end_r[v];
      if (tick_acc && play_r[v]) begin
        pos_nxt[v]  = pos_r[v] + 17'd1;
        play_nxt[v] = !(pos_nxt[v] >= end_r[v]);
      end
      if (trig_acc && voice_idx == VW'(v)) begin
        play_nxt[v] = 1'b1;
        pos_nxt[v]  = '0;
      end
      if (acc && in_op == OP_SET_LEN && vok && voice_idx == VW'(v)) begin
        end_nxt[v] = in_voice_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r <= '0;
      for (int v = 0; v < VOICES; v++) begin
        pos_r[v] <= '0;
        end_r[v] <= END_RESET[v];
      end
    end else begin
      play_r <= play_nxt;
      for (int v = 0; v < VOICES; v++) begin
        pos_r[v] <= pos_nxt[v];
        end_r[v] <= end_nxt[v];
      end
    end
  end

  // music position, buffer select, clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpos_r    <= '0;
      abuf_r    <= 1'b0;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == MPOS_LAST) begin
          clr_r <= 1'b0;
        end
      end
      if (tick_acc) begin
        mpos_r <= swap_now ? '0 : mpos_r + 1'b1;
        abuf_r <= abuf_r ^ swap_now;
      end
    end
  end

  assign side_nxt.swap = swap_now;
  assign side_nxt.fill = !(abuf_r ^ swap_now);

  for (genvar g = 0; g < 8; g++) begin : g_mask
    if (g < VOICES) begin : g_on
      assign side_nxt.mask[g] = play_nxt[g];
    end else begin : g_off
      assign side_nxt.mask[g] = 1'b0;
    end
  end

  // voice banks
  for (genvar g = 0; g < VOICES; g++) begin : g_bank
    logic [15:0] vmem [VOICE_DEPTH];
    logic        we;
    assign we = acc && (in_op == OP_WR_VOICE) && vok && vidx_ok && (voice_idx == VW'(g));
    always_ff @(posedge clk) begin
      if (we) begin
        vmem[in_index[AW-1:0]] <= in_sample_value;
      end
      if (en1) begin
        vrd_r[g] <= vmem[pos_r[g][AW-1:0]];
      end
    end
  end

  // music banks
  logic [15:0]   mmem0 [MUSIC_DEPTH];
  logic [15:0]   mmem1 [MUSIC_DEPTH];
  logic          mwe;
  logic [MW-1:0] mwaddr;
  logic [15:0]   mwdata;

  assign mwe    = acc && (in_op == OP_WR_MUSIC) && midx_ok;
  assign mwaddr = clr_r ? clr_cnt_r : in_index[MW-1:0];
  assign mwdata = clr_r ? 16'd0 : in_sample_value;

  always_ff @(posedge clk) begin
    if (clr_r || (mwe && !in_buffer_select)) begin
      mmem0[mwaddr] <= mwdata;
    end
    if (en1) begin
      mrd0_r <= mmem0[mpos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r || (mwe && in_buffer_select)) begin
      mmem1[mwaddr] <= mwdata;
    end
    if (en1) begin
      mrd1_r <= mmem1[mpos_r];
    end
  end

  // mix
  always_comb begin
    mix_nxt = MIX_BIAS;
    for (int v = 0; v < VOICES; v++) begin
      if (vmask1_r[v]) begin
        mix_nxt = mix_nxt + (vrd_r[v] ^ MIX_BIAS);
      end
    end
    mix_nxt = mix_nxt + (msel1_r ? mrd1_r : mrd0_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= tick_acc;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (adv_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      side1_r  <= side_nxt;
      vmask1_r <= play_r;
      msel1_r  <= abuf_r;
    end
    if (en2) begin
      side2_r <= side1_r;
      mix2_r  <= mix_nxt;
    end
    if (en3) begin
      side3_r <= side2_r;
      prod3_r <= {1'b0, mix2_r} * {16'd0, vol_r};
    end
    if (adv_out && v3_r) begin
      dac_r              <= prod3_r[32] ? SAMPLE_MAX : prod3_r[31:16];
      out_swap_pulse     <= side3_r.swap;
      out_buffer_to_fill <= side3_r.fill;
      out_active_voices  <= side3_r.mask;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dac_sample = dac_r;

  `SVM_ASSERT_SAME(a_clr_stall, clk, rst_n, clr_r, in_stall && !v1_r, "word taken during clear")
  `SVM_ASSERT_NEXT(a_tick_enters, clk, rst_n, tick_acc, v1_r, "tick lost at stage one")
  `SVM_ASSERT_NEXT(a_stage_hold, clk, rst_n, v3_r && !adv_out, v3_r, "stage three dropped")
  `SVM_ASSERT_NEXT(a_swap_wrap, clk, rst_n, tick_acc && swap_now, mpos_r == '0, "no wrap on swap")
  `SVM_ASSERT_NEXT(a_trig_play, clk, rst_n, trig_acc, play_r[$past(voice_idx)], "trigger ignored")

endmodule
